// ===== rtl/hbe_pkg.sv =====
// Shared constants and types for the Huffman bit encoder.
package hbe_pkg;

  // Default sizes
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int SYMBOL_COUNT_DEF  = 256;

  // Fixed field widths
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int SYM_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int ACTION_W = 2;

  // Item actions
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

  // One code table entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

// ===== rtl/hbe_table.sv =====
// Code table: one write port, one registered read port.
module hbe_table #(
  parameter int SYMBOL_COUNT = hbe_pkg::SYMBOL_COUNT_DEF,
  parameter int ADDR_W       = $clog2(SYMBOL_COUNT)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  hbe_pkg::entry_t      wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output hbe_pkg::entry_t      rdata
);
  import hbe_pkg::*;

  entry_t mem [SYMBOL_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/huffman_bit_encoder.sv =====
// Huffman bit encoder: a load item writes a table entry as it is accepted; an encode
// item is accepted and reads the table, S_FETCH captures the entry, then the packer
// moves up to one byte per cycle while the output does not stall, until all L bits of
// the code are packed. A flush emits a partial byte when bits are pending, else it
// does nothing. No new item is accepted until an encode or a flush is done. The rate
// is set by the table read latency and by the packer emitting one byte per cycle, when
// the output does not stall, into a single output register. Table entries hold no
// value until loaded; there is no clearing pass after reset.
module huffman_bit_encoder #(
  parameter int MAX_CODE_BITS = hbe_pkg::MAX_CODE_BITS_DEF,
  parameter int SYMBOL_COUNT  = hbe_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hbe_pkg::ACTION_W-1:0]   action,
  input  logic [hbe_pkg::SYM_W-1:0]      symbol,
  input  logic [hbe_pkg::CODE_W-1:0]     code_bits,
  input  logic [hbe_pkg::LEN_W-1:0]      code_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hbe_pkg::BYTE_W-1:0]     out_byte,
  output logic                           last
);
  import hbe_pkg::*;

  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int REM_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int CNT_W  = $clog2(BYTE_W);
  localparam int K_W    = $clog2(BYTE_W + 1);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_STEP, S_FLUSH} state_t;

  state_t              state;
  logic [BYTE_W-2:0]   pbits;
  logic [CNT_W-1:0]    pcount;
  logic [CODE_W-1:0]   code;
  logic [REM_W-1:0]    rem;

  logic                in_fire;
  logic                sym_ok;
  logic                out_free;
  logic                emit_byte;
  logic                tbl_we;
  logic                tbl_re;
  entry_t              tbl_wdata;
  entry_t              tbl_rdata;
  logic [LEN_W-1:0]    sat_len;

  // packer step signals
  logic [K_W-1:0]      avail;
  logic [K_W-1:0]      k;
  logic [REM_W-1:0]    shift;
  logic [BYTE_W-1:0]   mask;
  logic [BYTE_W-1:0]   take;
  logic [BYTE_W-1:0]   ext;
  logic [BYTE_W-1:0]   packed_byte;
  logic [K_W-1:0]      fill;
  logic                step_full;
  logic [BYTE_W-1:0]   flush_byte;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign sym_ok   = int'(symbol) < SYMBOL_COUNT;
  assign out_free = !out_valid || out_ready;

  // output register loads a new byte this cycle
  assign emit_byte = out_free && ((state == S_STEP && rem != '0 && step_full) ||
                                  (state == S_FLUSH));

  // table write on load, read on encode
  assign sat_len   = (int'(code_length) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                          : code_length;
  assign tbl_wdata = '{len: sat_len, code: code_bits};
  assign tbl_we    = in_fire && (action == ACT_LOAD) && sym_ok;
  assign tbl_re    = in_fire && (action == ACT_ENCODE) && sym_ok;

  hbe_table #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(symbol[ADDR_W-1:0]),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(symbol[ADDR_W-1:0]),
    .rdata(tbl_rdata)
  );

  // one packer step: take as many code bits as fit in the current byte
  always_comb begin
    avail       = K_W'(BYTE_W) - K_W'(pcount);
    k           = (rem < REM_W'(avail)) ? K_W'(rem) : avail;
    shift       = rem - REM_W'(k);
    mask        = {BYTE_W{1'b1}} >> (K_W'(BYTE_W) - k);
    take        = BYTE_W'(code >> shift) & mask;
    ext         = {1'b0, pbits};
    packed_byte = (ext << k) | take;
    fill        = K_W'(pcount) + k;
    step_full   = (fill == K_W'(BYTE_W));
    flush_byte  = ext << (K_W'(BYTE_W) - K_W'(pcount));
  end

  // control, packer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pbits     <= '0;
      pcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_byte) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (action == ACT_ENCODE && sym_ok) begin
              state <= S_FETCH;
            end else if (action == ACT_FLUSH && pcount != '0) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FETCH: begin
          code  <= tbl_rdata.code;
          rem   <= REM_W'(tbl_rdata.len);
          state <= S_STEP;
        end
        S_STEP: begin
          if (rem == '0) begin
            state <= S_IDLE;
          end else if (!step_full) begin
            pbits  <= packed_byte[BYTE_W-2:0];
            pcount <= CNT_W'(fill);
            rem    <= shift;
            state  <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= packed_byte;
            last      <= 1'b0;
            pbits     <= '0;
            pcount    <= '0;
            rem       <= shift;
            if (shift == '0) begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= flush_byte;
            last      <= 1'b1;
            pbits     <= '0;
            pcount    <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a step that completes a byte emits it and empties the packer
  a_step_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && rem != '0 && step_full && out_free)
      |=> (out_valid && !last && pcount == '0))
    else $error("packer step did not emit its byte");

  // a step that leaves a partial byte ends the encode
  a_step_partial: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && rem != '0 && !step_full) |=> (state == S_IDLE && pcount != '0))
    else $error("partial step did not end the encode");

  // a flush emits a last byte and clears the packer
  a_flush_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |=> (out_valid && last && pcount == '0))
    else $error("flush did not emit a last byte");

  // an empty flush leaves the block idle
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (in_fire && action == ACT_FLUSH && pcount == '0) |=> (state == S_IDLE))
    else $error("empty flush did not stay idle");

  // the remaining code count never passes the maximum code length
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (int'(rem) <= MAX_CODE_BITS))
    else $error("remaining code bits out of range");
`endif

endmodule

// ===== tb/sv/huffman_bit_encoder_tb.sv =====
// Self-checking testbench for the Huffman bit encoder: table loads, encodes, flushes.
module huffman_bit_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbe_pkg::*;

  // Action code the block must ignore
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 150;

  // One packed output byte as the block should emit it
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_byte_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] action      = ACT_LOAD;
  logic [SYM_W-1:0]    symbol      = '0;
  logic [CODE_W-1:0]   code_bits   = '0;
  logic [LEN_W-1:0]    code_length = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                last;

  // Local copy of the code table and the bit packer
  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT_DEF];
  int                len_mem  [SYMBOL_COUNT_DEF];
  bit                loaded   [SYMBOL_COUNT_DEF];
  logic [SYM_W-1:0]  loaded_syms [$];
  logic [BYTE_W-1:0] pend_bits = '0;
  int                pend_cnt  = 0;

  packed_byte_t expected_bytes [$];
  packed_byte_t got;
  int           error_count  = 0;
  bit           idle_en      = 1'b1;
  int           out_hold_len = 0;

  huffman_bit_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Update the table / packer for one accepted item and queue the bytes it emits
  function automatic void advance_packer(input logic [ACTION_W-1:0] act,
                                         input logic [SYM_W-1:0] sym,
                                         input logic [CODE_W-1:0] bits,
                                         input logic [LEN_W-1:0] len);
    int                pos;
    logic              bit_in;
    logic [BYTE_W-1:0] flush_byte;
    case (act)
      ACT_LOAD: begin
        if (int'(sym) < SYMBOL_COUNT_DEF) begin
          code_mem[sym] = bits;
          len_mem[sym]  = (int'(len) > MAX_CODE_BITS_DEF) ? MAX_CODE_BITS_DEF : int'(len);
          if (!loaded[sym]) begin
            loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
          end
        end
      end
      ACT_ENCODE: begin
        if (int'(sym) < SYMBOL_COUNT_DEF) begin
          for (pos = len_mem[sym] - 1; pos >= 0; pos--) begin
            bit_in    = (pos < CODE_W) ? code_mem[sym][pos] : 1'b0;
            pend_bits = {pend_bits[BYTE_W-2:0], bit_in};
            pend_cnt++;
            if (pend_cnt == BYTE_W) begin
              expected_bytes.push_back('{value: pend_bits, last: 1'b0});
              pend_bits = '0;
              pend_cnt  = 0;
            end
          end
        end
      end
      ACT_FLUSH: begin
        if (pend_cnt != 0) begin
          flush_byte = pend_bits << (BYTE_W - pend_cnt);
          expected_bytes.push_back('{value: flush_byte, last: 1'b1});
          pend_bits = '0;
          pend_cnt  = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one item, wait for acceptance, then predict; valid stays high on return
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    symbol      <= sym;
    code_bits   <= bits;
    code_length <= len;
    do @(posedge clk); while (!in_ready);
    advance_packer(act, sym, bits, len);
  endtask

  // Only symbols with a loaded entry may be encoded
  function automatic logic [SYM_W-1:0] pick_loaded_symbol();
    return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
  endfunction

  // Mostly short codes, some long, a few zero and over-range lengths
  function automatic logic [LEN_W-1:0] rand_code_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(MAX_CODE_BITS_DEF + 1, 63));
    if (r < 4) return LEN_W'($urandom_range(17, MAX_CODE_BITS_DEF));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  // Receiver: random short stalls, or one long hold-off on request
  always begin
    @(negedge clk);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold_len != 0) begin
      out_ready <= 1'b0;
      repeat (out_hold_len) @(negedge clk);
      out_hold_len = 0;
      out_ready <= 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each emitted byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual out_byte %02h last %0b",
                 $time, out_byte, last);
        error_count++;
      end else begin
        got = expected_bytes.pop_front();
        if (out_byte !== got.value) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, got.value, out_byte);
          error_count++;
        end
        if (last !== got.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, got.last, last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any accepted item on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // All-ones 32-bit code, single zero bit, 8-bit pattern A5
  task automatic test_table_extremes();
    send_item(ACT_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_item(ACT_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    send_item(ACT_LOAD, 8'h5A, 32'h0000_00A5, 6'd8);
    send_item(ACT_ENCODE, 8'h00, '0, '0);
    send_item(ACT_ENCODE, 8'h5A, '0, '0);
    send_item(ACT_ENCODE, 8'hFF, '0, '0);
    send_item(ACT_FLUSH, '0, '0, '0);
  endtask

  // Lengths above the maximum saturate
  task automatic test_long_codes();
    send_item(ACT_LOAD, 8'h01, 32'h8000_0001, 6'd63);
    send_item(ACT_ENCODE, 8'h01, '0, '0);
    send_item(ACT_LOAD, 8'h02, 32'h1234_5678, 6'd33);
    send_item(ACT_ENCODE, 8'h02, '0, '0);
    send_item(ACT_FLUSH, '0, '0, '0);
  endtask

  // A zero-length code adds nothing to the packer
  task automatic test_zero_length();
    send_item(ACT_LOAD, 8'h03, 32'hFFFF_FFFF, 6'd0);
    send_item(ACT_ENCODE, 8'h03, '0, '0);
    send_item(ACT_ENCODE, 8'hFF, '0, '0);
    send_item(ACT_ENCODE, 8'h03, '0, '0);
    send_item(ACT_FLUSH, '0, '0, '0);
  endtask

  // Flush on an empty packer, then on a partial byte
  task automatic test_flush_cases();
    send_item(ACT_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_item(ACT_ENCODE, 8'hFF, '0, '0);
    send_item(ACT_ENCODE, 8'h00, '0, '0);
    send_item(ACT_ENCODE, 8'hFF, '0, '0);
    send_item(ACT_FLUSH, '0, '0, '0);
  endtask

  // Action 3 is ignored whatever the payload
  task automatic test_unused_action();
    send_item(ACT_UNUSED, 8'h00, 32'hFFFF_FFFF, 6'h3F);
    send_item(ACT_UNUSED, 8'hFF, 32'h0000_0000, 6'd0);
  endtask

  // Mostly encodes of loaded symbols, with loads, flushes and ignored items mixed in
  task automatic test_random_stream(input int count);
    int i;
    int pick;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (loaded_syms.size() == 0 || pick < 15)
        send_item(ACT_LOAD, SYM_W'($urandom), $urandom, rand_code_length());
      else if (pick < 85)
        send_item(ACT_ENCODE, pick_loaded_symbol(), $urandom, LEN_W'($urandom));
      else if (pick < 95)
        send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      else
        send_item(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
    end
  endtask

  // Receiver holds off while full-length codes keep coming, so the input stalls
  task automatic test_output_backpressure();
    int i;
    send_item(ACT_LOAD, 8'h77, $urandom, 6'd32);
    out_hold_len = HOLD_CYCLES;
    for (i = 0; i < 16; i++)
      send_item(ACT_ENCODE, 8'h77, '0, '0);
    send_item(ACT_ENCODE, pick_loaded_symbol(), '0, '0);
    send_item(ACT_FLUSH, '0, '0, '0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_extremes();
    test_long_codes();
    test_zero_length();
    test_flush_cases();
    test_unused_action();
    test_random_stream(80);
    test_output_backpressure();
    idle_en = 1'b0;
    test_random_stream(30);
    send_item(ACT_FLUSH, '0, '0, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
